// ===== rtl/gedge_pkg.sv =====
// Shared types, codes and default sizes of the grouped edge table.
package gedge_pkg;

    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_MAX_EDGES = 64;
    localparam int DEF_STEP_BITS = 16;

    // Fixed field widths of the stream beats.
    localparam int NODE_W      = 6;
    localparam int STEP_IN_W   = 16;
    localparam int STATUS_W    = 3;
    localparam int OP_W        = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_NODE = 2'd0,
        OP_ADD_EDGE = 2'd1,
        OP_ADD_BOTH = 2'd2,
        OP_QUERY    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_VERTEX = 3'd1,
        ST_EDGES_FULL = 3'd2,
        ST_NODES_FULL = 3'd3,
        ST_NO_EDGES   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_INS_GRP,
        S_GSWEEP,
        S_ESHIFT,
        S_QRY,
        S_Q_GRP,
        S_Q_RD,
        S_Q_OUT,
        S_EMIT
    } state_t;

endpackage

// ===== rtl/gedge_ram.sv =====
// Simple dual-port synchronous RAM with one write port and a registered read port.
module gedge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/gedge_ctrl.sv =====
// Sequencer of the edge table: operation decode, table sweeps, edge shifting and result register.
module gedge_ctrl #(
    parameter int MAX_NODES = gedge_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = gedge_pkg::DEF_MAX_EDGES,
    parameter int STEP_BITS = gedge_pkg::DEF_STEP_BITS,
    localparam int GN  = (MAX_NODES < (1 << gedge_pkg::NODE_W)) ? MAX_NODES
                                                             : (1 << gedge_pkg::NODE_W),
    localparam int GAW = $clog2(GN),
    localparam int EAW = $clog2(MAX_EDGES),
    localparam int ECW = $clog2(MAX_EDGES + 1),
    localparam int GEW = 2 * ECW,
    localparam int EEW = gedge_pkg::NODE_W + 2 * STEP_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input beat
    input  logic                               in_valid,
    output logic                               in_ready,
    input  gedge_pkg::op_t                     in_op,
    input  logic [gedge_pkg::NODE_W-1:0]       in_src,
    input  logic [gedge_pkg::NODE_W-1:0]       in_dst,
    input  logic [gedge_pkg::STEP_IN_W-1:0]    in_dx,
    input  logic [gedge_pkg::STEP_IN_W-1:0]    in_dy,
    // Result beat
    output logic                               out_valid,
    input  logic                               out_ready,
    output gedge_pkg::status_t                 out_status,
    output logic                               out_edge_valid,
    output logic [gedge_pkg::NODE_W-1:0]       out_neighbor,
    output logic [gedge_pkg::STEP_IN_W-1:0]    out_dx,
    output logic [gedge_pkg::STEP_IN_W-1:0]    out_dy,
    output logic                               out_last,
    // Group table port
    output logic                               grp_wr_en,
    output logic [GAW-1:0]                     grp_wr_addr,
    output logic [GEW-1:0]                     grp_wr_data,
    output logic                               grp_rd_en,
    output logic [GAW-1:0]                     grp_rd_addr,
    input  logic [GEW-1:0]                     grp_rd_data,
    // Edge table port
    output logic                               edge_wr_en,
    output logic [EAW-1:0]                     edge_wr_addr,
    output logic [EEW-1:0]                     edge_wr_data,
    output logic                               edge_rd_en,
    output logic [EAW-1:0]                     edge_rd_addr,
    input  logic [EEW-1:0]                     edge_rd_data
);

    localparam int NW  = gedge_pkg::NODE_W;
    localparam int SW  = STEP_BITS;
    localparam int KB  = (SW < gedge_pkg::STEP_IN_W) ? SW : gedge_pkg::STEP_IN_W;
    localparam int GIW = $clog2(GN + 1);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam logic [SW-1:0] STEP_MIN = {1'b1, {(SW - 1){1'b0}}};

    // Negation that saturates the most negative step to the largest positive one.
    function automatic logic [SW-1:0] neg_sat(input logic [SW-1:0] v);
        logic [SW-1:0] r;
        if (v == STEP_MIN)
        begin
            r = STEP_MIN - SW'(1);
        end
        else
        begin
            r = SW'(0) - v;
        end
        return r;
    endfunction

    gedge_pkg::state_t  state_reg, state_next;
    logic [NCW-1:0]     node_count_reg, node_count_next;
    logic [ECW-1:0]     edge_total_reg, edge_total_next;
    logic               second_reg, second_next;
    logic               gpend_reg, gpend_next;
    logic               epend_reg, epend_next;
    logic               out_valid_reg, out_valid_next;

    gedge_pkg::op_t     op_reg, op_next;
    logic [NW-1:0]      src_reg, src_next;
    logic [NW-1:0]      dst_reg, dst_next;
    logic [SW-1:0]      dx_reg, dx_next;
    logic [SW-1:0]      dy_reg, dy_next;
    gedge_pkg::status_t status_reg, status_next;
    logic [ECW-1:0]     pos_reg, pos_next;
    logic [ECW-1:0]     eidx_reg, eidx_next;
    logic [EAW-1:0]     ewr_idx_reg, ewr_idx_next;
    logic [GIW-1:0]     gidx_reg, gidx_next;
    logic [GAW-1:0]     gwr_idx_reg, gwr_idx_next;
    logic [ECW-1:0]     cnt_reg, cnt_next;

    gedge_pkg::status_t           out_status_reg, out_status_next;
    logic                         out_edge_valid_reg, out_edge_valid_next;
    logic [NW-1:0]                out_neighbor_reg, out_neighbor_next;
    logic [gedge_pkg::STEP_IN_W-1:0] out_dx_reg, out_dx_next;
    logic [gedge_pkg::STEP_IN_W-1:0] out_dy_reg, out_dy_next;
    logic                         out_last_reg, out_last_next;

    logic           out_free;
    logic [GIW-1:0] glim;
    logic [ECW-1:0] eidx_dec;
    logic [ECW-1:0] grp_start;
    logic [ECW-1:0] grp_size;
    logic           src_bad;

    assign out_free  = !out_valid_reg || out_ready;
    assign glim      = (node_count_reg >= NCW'(GN)) ? GIW'(GN) : GIW'(node_count_reg);
    assign eidx_dec  = eidx_reg - ECW'(1);
    assign grp_start = grp_rd_data[ECW-1:0];
    assign grp_size  = grp_rd_data[GEW-1:ECW];
    assign src_bad   = ({{NCW{1'b0}}, src_reg} >= {{NW{1'b0}}, node_count_reg});

    always_comb
    begin
        state_next          = state_reg;
        node_count_next     = node_count_reg;
        edge_total_next     = edge_total_reg;
        second_next         = second_reg;
        gpend_next          = gpend_reg;
        epend_next          = epend_reg;
        op_next             = op_reg;
        src_next            = src_reg;
        dst_next            = dst_reg;
        dx_next             = dx_reg;
        dy_next             = dy_reg;
        status_next         = status_reg;
        pos_next            = pos_reg;
        eidx_next           = eidx_reg;
        ewr_idx_next        = ewr_idx_reg;
        gidx_next           = gidx_reg;
        gwr_idx_next        = gwr_idx_reg;
        cnt_next            = cnt_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        out_status_next     = out_status_reg;
        out_edge_valid_next = out_edge_valid_reg;
        out_neighbor_next   = out_neighbor_reg;
        out_dx_next         = out_dx_reg;
        out_dy_next         = out_dy_reg;
        out_last_next       = out_last_reg;
        in_ready            = 1'b0;
        grp_wr_en           = 1'b0;
        grp_wr_addr         = '0;
        grp_wr_data         = '0;
        grp_rd_en           = 1'b0;
        grp_rd_addr         = '0;
        edge_wr_en          = 1'b0;
        edge_wr_addr        = '0;
        edge_wr_data        = '0;
        edge_rd_en          = 1'b0;
        edge_rd_addr        = '0;

        unique case (state_reg)
            gedge_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next     = in_op;
                    src_next    = in_src;
                    dst_next    = in_dst;
                    dx_next     = SW'(in_dx[KB-1:0]);
                    dy_next     = SW'(in_dy[KB-1:0]);
                    second_next = 1'b0;
                    unique case (in_op)
                        gedge_pkg::OP_ADD_NODE:
                        begin
                            // A new node gets an empty group at the end of the edge table.
                            if (node_count_reg >= NCW'(MAX_NODES))
                            begin
                                status_next = gedge_pkg::ST_NODES_FULL;
                            end
                            else
                            begin
                                grp_wr_en       = (node_count_reg < NCW'(GN));
                                grp_wr_addr     = node_count_reg[GAW-1:0];
                                grp_wr_data     = {{ECW{1'b0}}, edge_total_reg};
                                node_count_next = node_count_reg + NCW'(1);
                                status_next     = gedge_pkg::ST_OK;
                            end
                            state_next = gedge_pkg::S_EMIT;
                        end
                        gedge_pkg::OP_ADD_EDGE,
                        gedge_pkg::OP_ADD_BOTH:
                        begin
                            state_next = gedge_pkg::S_INS;
                        end
                        gedge_pkg::OP_QUERY:
                        begin
                            state_next = gedge_pkg::S_QRY;
                        end
                        default:
                        begin
                            state_next = gedge_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            gedge_pkg::S_INS:
            begin
                priority if (src_bad)
                begin
                    status_next = gedge_pkg::ST_BAD_VERTEX;
                    state_next  = gedge_pkg::S_EMIT;
                end
                else if (edge_total_reg >= ECW'(MAX_EDGES))
                begin
                    status_next = gedge_pkg::ST_EDGES_FULL;
                    state_next  = gedge_pkg::S_EMIT;
                end
                else
                begin
                    grp_rd_en   = 1'b1;
                    grp_rd_addr = src_reg[GAW-1:0];
                    state_next  = gedge_pkg::S_INS_GRP;
                end
            end

            gedge_pkg::S_INS_GRP:
            begin
                // The new edge goes to the front of the source's group.
                grp_wr_en    = 1'b1;
                grp_wr_addr  = src_reg[GAW-1:0];
                grp_wr_data  = {grp_size + ECW'(1), grp_start};
                pos_next     = grp_start;
                eidx_next    = edge_total_reg;
                gidx_next    = GIW'(src_reg[GAW-1:0]) + GIW'(1);
                gpend_next   = 1'b0;
                state_next   = gedge_pkg::S_GSWEEP;
            end

            gedge_pkg::S_GSWEEP:
            begin
                // Read one higher node per cycle and write it back in the next cycle.
                if (gpend_reg)
                begin
                    grp_wr_en   = 1'b1;
                    grp_wr_addr = gwr_idx_reg;
                    grp_wr_data = {grp_size, grp_start + ECW'(1)};
                end
                if (gidx_reg < glim)
                begin
                    grp_rd_en    = 1'b1;
                    grp_rd_addr  = gidx_reg[GAW-1:0];
                    gwr_idx_next = gidx_reg[GAW-1:0];
                    gidx_next    = gidx_reg + GIW'(1);
                    gpend_next   = 1'b1;
                end
                else
                begin
                    gpend_next = 1'b0;
                    if (!gpend_reg)
                    begin
                        epend_next = 1'b0;
                        state_next = gedge_pkg::S_ESHIFT;
                    end
                end
            end

            gedge_pkg::S_ESHIFT:
            begin
                // Move edges up from the top down to the insert position, then fill the gap.
                priority if (epend_reg)
                begin
                    edge_wr_en   = 1'b1;
                    edge_wr_addr = ewr_idx_reg;
                    edge_wr_data = edge_rd_data;
                end
                else if (eidx_reg == pos_reg)
                begin
                    edge_wr_en      = 1'b1;
                    edge_wr_addr    = pos_reg[EAW-1:0];
                    edge_wr_data    = {dy_reg, dx_reg, dst_reg};
                    edge_total_next = edge_total_reg + ECW'(1);
                    if ((op_reg == gedge_pkg::OP_ADD_BOTH) && !second_reg)
                    begin
                        second_next = 1'b1;
                        src_next    = dst_reg;
                        dst_next    = src_reg;
                        dx_next     = neg_sat(dx_reg);
                        dy_next     = neg_sat(dy_reg);
                        state_next  = gedge_pkg::S_INS;
                    end
                    else
                    begin
                        status_next = gedge_pkg::ST_OK;
                        state_next  = gedge_pkg::S_EMIT;
                    end
                end
                else
                begin
                    edge_wr_en = 1'b0;
                end
                if (eidx_reg > pos_reg)
                begin
                    edge_rd_en   = 1'b1;
                    edge_rd_addr = eidx_dec[EAW-1:0];
                    ewr_idx_next = eidx_reg[EAW-1:0];
                    eidx_next    = eidx_dec;
                    epend_next   = 1'b1;
                end
                else
                begin
                    epend_next = 1'b0;
                end
            end

            gedge_pkg::S_QRY:
            begin
                if (src_bad)
                begin
                    status_next = gedge_pkg::ST_BAD_VERTEX;
                    state_next  = gedge_pkg::S_EMIT;
                end
                else
                begin
                    grp_rd_en   = 1'b1;
                    grp_rd_addr = src_reg[GAW-1:0];
                    state_next  = gedge_pkg::S_Q_GRP;
                end
            end

            gedge_pkg::S_Q_GRP:
            begin
                if (grp_size == '0)
                begin
                    status_next = gedge_pkg::ST_NO_EDGES;
                    state_next  = gedge_pkg::S_EMIT;
                end
                else
                begin
                    eidx_next  = grp_start;
                    cnt_next   = grp_size;
                    state_next = gedge_pkg::S_Q_RD;
                end
            end

            gedge_pkg::S_Q_RD:
            begin
                edge_rd_en   = 1'b1;
                edge_rd_addr = eidx_reg[EAW-1:0];
                state_next   = gedge_pkg::S_Q_OUT;
            end

            gedge_pkg::S_Q_OUT:
            begin
                // The read data stays in the RAM register until the result slot frees.
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_status_next     = gedge_pkg::ST_OK;
                    out_edge_valid_next = 1'b1;
                    out_neighbor_next   = edge_rd_data[NW-1:0];
                    out_dx_next         = gedge_pkg::STEP_IN_W'(edge_rd_data[NW+KB-1:NW]);
                    out_dy_next         =
                        gedge_pkg::STEP_IN_W'(edge_rd_data[NW+SW+KB-1:NW+SW]);
                    out_last_next       = (cnt_reg == ECW'(1));
                    eidx_next           = eidx_reg + ECW'(1);
                    cnt_next            = cnt_reg - ECW'(1);
                    state_next          = (cnt_reg == ECW'(1)) ? gedge_pkg::S_IDLE
                                                               : gedge_pkg::S_Q_RD;
                end
            end

            gedge_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_status_next     = status_reg;
                    out_edge_valid_next = 1'b0;
                    out_neighbor_next   = '0;
                    out_dx_next         = '0;
                    out_dy_next         = '0;
                    out_last_next       = 1'b1;
                    state_next          = gedge_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = gedge_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gedge_pkg::S_IDLE;
            node_count_reg <= '0;
            edge_total_reg <= '0;
            second_reg     <= 1'b0;
            gpend_reg      <= 1'b0;
            epend_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            edge_total_reg <= edge_total_next;
            second_reg     <= second_next;
            gpend_reg      <= gpend_next;
            epend_reg      <= epend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg             <= op_next;
        src_reg            <= src_next;
        dst_reg            <= dst_next;
        dx_reg             <= dx_next;
        dy_reg             <= dy_next;
        status_reg         <= status_next;
        pos_reg            <= pos_next;
        eidx_reg           <= eidx_next;
        ewr_idx_reg        <= ewr_idx_next;
        gidx_reg           <= gidx_next;
        gwr_idx_reg        <= gwr_idx_next;
        cnt_reg            <= cnt_next;
        out_status_reg     <= out_status_next;
        out_edge_valid_reg <= out_edge_valid_next;
        out_neighbor_reg   <= out_neighbor_next;
        out_dx_reg         <= out_dx_next;
        out_dy_reg         <= out_dy_next;
        out_last_reg       <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_edge_valid = out_edge_valid_reg;
    assign out_neighbor   = out_neighbor_reg;
    assign out_dx         = out_dx_reg;
    assign out_dy         = out_dy_reg;
    assign out_last       = out_last_reg;

    // The sweeps never read and write the same table entry in one cycle.
    a_grp_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (grp_wr_en && grp_rd_en) |-> (grp_wr_addr != grp_rd_addr))
        else $error("group table read and write hit the same entry");

    a_edge_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (edge_wr_en && edge_rd_en) |-> (edge_wr_addr != edge_rd_addr))
        else $error("edge table read and write hit the same entry");

    a_edge_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        (edge_total_reg != $past(edge_total_reg))
            |-> (($past(state_reg) == gedge_pkg::S_ESHIFT)
                 && (edge_total_reg == $past(edge_total_reg) + ECW'(1))))
        else $error("edge count changed outside an insertion");

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (edge_total_reg <= ECW'(MAX_EDGES)) && (node_count_reg <= NCW'(MAX_NODES)))
        else $error("node or edge count beyond capacity");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_status_reg)
                                           && $stable(out_last_reg)))
        else $error("pending result overwritten");

endmodule

// ===== rtl/grouped_edge_table.sv =====
// Top level of the grouped edge table: stream ports, group and edge RAMs, sequencer.
// An item is taken only in the idle state, so items are handled one at a time; an
// add-edge runs read-modify-write sweeps over the group entries above the source and the
// edges behind the insert point, twice for an edge added both ways, and a query emits one
// result beat per edge of the source.
// Reset clears the node and edge counts and the result slot; the RAMs are not cleared.
module grouped_edge_table #(
    parameter int MAX_NODES = gedge_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = gedge_pkg::DEF_MAX_EDGES,
    parameter int STEP_BITS = gedge_pkg::DEF_STEP_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream: one beat per operation.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata, from bit 0: source_node[5:0], dest_node[11:6], step_x[27:12],
    // step_y[43:28], zero fill [47:44].
    input  logic [gedge_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: op[1:0].
    input  logic [gedge_pkg::OP_W-1:0]          s_axis_tuser,
    // Result stream: tlast marks the final result beat of an operation.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata, from bit 0: neighbor[5:0], neighbor_step_x[21:6],
    // neighbor_step_y[37:22], zero fill [39:38].
    output logic [gedge_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // tuser, from bit 0: status[2:0], edge_valid[3].
    output logic [gedge_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
    output logic                                m_axis_tlast
);

    // Only nodes that a six-bit source can name ever have their group read, so the
    // group RAM holds at most that many entries.
    localparam int GN  = (MAX_NODES < (1 << gedge_pkg::NODE_W)) ? MAX_NODES
                                                             : (1 << gedge_pkg::NODE_W);
    localparam int GAW = $clog2(GN);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int ECW = $clog2(MAX_EDGES + 1);
    // A group entry holds {size, start}.
    localparam int GEW = 2 * ECW;
    // An edge entry holds {step_y, step_x, destination}.
    localparam int EEW = gedge_pkg::NODE_W + 2 * STEP_BITS;
    localparam int NW  = gedge_pkg::NODE_W;
    localparam int SIW = gedge_pkg::STEP_IN_W;

    gedge_pkg::status_t     res_status;
    logic                   res_edge_valid;
    logic [NW-1:0]          res_neighbor;
    logic [SIW-1:0]         res_dx;
    logic [SIW-1:0]         res_dy;

    logic                   grp_wr_en;
    logic [GAW-1:0]         grp_wr_addr;
    logic [GEW-1:0]         grp_wr_data;
    logic                   grp_rd_en;
    logic [GAW-1:0]         grp_rd_addr;
    logic [GEW-1:0]         grp_rd_data;

    logic                   edge_wr_en;
    logic [EAW-1:0]         edge_wr_addr;
    logic [EEW-1:0]         edge_wr_data;
    logic                   edge_rd_en;
    logic [EAW-1:0]         edge_rd_addr;
    logic [EEW-1:0]         edge_rd_data;

    gedge_ctrl #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES),
        .STEP_BITS (STEP_BITS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_op          (gedge_pkg::op_t'(s_axis_tuser)),
        .in_src         (s_axis_tdata[NW-1:0]),
        .in_dst         (s_axis_tdata[2*NW-1:NW]),
        .in_dx          (s_axis_tdata[2*NW+SIW-1:2*NW]),
        .in_dy          (s_axis_tdata[2*NW+2*SIW-1:2*NW+SIW]),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_status     (res_status),
        .out_edge_valid (res_edge_valid),
        .out_neighbor   (res_neighbor),
        .out_dx         (res_dx),
        .out_dy         (res_dy),
        .out_last       (m_axis_tlast),
        .grp_wr_en      (grp_wr_en),
        .grp_wr_addr    (grp_wr_addr),
        .grp_wr_data    (grp_wr_data),
        .grp_rd_en      (grp_rd_en),
        .grp_rd_addr    (grp_rd_addr),
        .grp_rd_data    (grp_rd_data),
        .edge_wr_en     (edge_wr_en),
        .edge_wr_addr   (edge_wr_addr),
        .edge_wr_data   (edge_wr_data),
        .edge_rd_en     (edge_rd_en),
        .edge_rd_addr   (edge_rd_addr),
        .edge_rd_data   (edge_rd_data)
    );

    // Group table: start and size of each node's run of edges.
    gedge_ram #(
        .WIDTH (GEW),
        .DEPTH (GN)
    ) u_grp_ram (
        .clk     (clk),
        .wr_en   (grp_wr_en),
        .wr_addr (grp_wr_addr),
        .wr_data (grp_wr_data),
        .rd_en   (grp_rd_en),
        .rd_addr (grp_rd_addr),
        .rd_data (grp_rd_data)
    );

    // Edge table: edges stored contiguously, grouped by source, newest first.
    gedge_ram #(
        .WIDTH (EEW),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (edge_wr_en),
        .wr_addr (edge_wr_addr),
        .wr_data (edge_wr_data),
        .rd_en   (edge_rd_en),
        .rd_addr (edge_rd_addr),
        .rd_data (edge_rd_data)
    );

    assign m_axis_tdata = {2'b00, res_dy, res_dx, res_neighbor};
    assign m_axis_tuser = {res_edge_valid, res_status};

endmodule
